FILE: rtl/ffl_pkg.sv
// ffl_pkg: shared types and codes for the free-list id allocator
// item layouts for the command and result ports, action and status codes
// no dependencies
`default_nettype none
package ffl_pkg;

	localparam int ID_W     = 7;
	localparam int ACT_W    = 2;
	localparam int IN_VAL_W = 32;
	localparam int FOUND_W  = 32;
	localparam int STATUS_W = 2;

	localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FREE   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0]    action;
		logic [ID_W-1:0]     given_id;
		logic [IN_VAL_W-1:0] stored_value;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0]     new_id;
		logic [FOUND_W-1:0]  found_value;
		logic [STATUS_W-1:0] status;
	} rsp_t;

endpackage
`default_nettype wire

FILE: rtl/ffl_ram.sv
// ffl_ram: one write port, one read port memory with registered read data
// a write and a read of the same address in one cycle return the new data
// no dependencies
`default_nettype none
module ffl_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/fifo_free_list_id_allocator.sv
// fifo_free_list_id_allocator: id allocator with fresh entries first, then a fifo free list
// result strobe (done) is raised in the cycle after the item is taken
// throughput: one item per cycle, busy is never raised; the receiver cannot stall
// reset: no ids in use, free list empty; stored values and links undefined until written
// uses ffl_pkg and two ffl_ram instances (bound values, free-list links)
`default_nettype none
module fifo_free_list_id_allocator #(
	parameter int CAPACITY   = 64,
	parameter int ID_BASE    = 8,
	parameter int VALUE_BITS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire ffl_pkg::cmd_t cmd,
	output logic               done,
	output ffl_pkg::rsp_t      result
);

	import ffl_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = AW + 1;
	localparam int DW = ((AW > 9) ? AW : 9) + 1;
	localparam logic [DW-1:0] BASE_D = DW'(ID_BASE);
	localparam logic [DW-1:0] CAP_D  = DW'(CAPACITY);
	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);

	logic [CW-1:0]   used_q, used_n;
	logic [ID_W-1:0] head_q, head_n;
	logic [ID_W-1:0] tail_q, tail_n;
	logic [ID_W-1:0] tail_link_q, tail_link_n;

	logic                done_q;
	logic                hit_q;
	logic [ID_W-1:0]     new_id_q, new_id_n;
	logic [STATUS_W-1:0] status_q, status_n;
	logic                hit_n;

	logic [DW-1:0] head_d, tail_d, id_d, next_d;
	logic          head_ok, tail_ok, id_ok;
	logic [ID_W-1:0] link_rd, head_link;

	logic                  v_we;
	logic [AW-1:0]         v_waddr;
	logic [VALUE_BITS-1:0] v_wdata, v_in, v_rd;
	logic                  l_we;
	logic [AW-1:0]         l_waddr;
	logic [ID_W-1:0]       l_wdata;

	assign busy = 1'b0;

	// value truncated or widened to the stored width
	always_comb begin
		v_in = '0;
		for (int b = 0; b < VALUE_BITS && b < IN_VAL_W; b++) begin
			v_in[b] = cmd.stored_value[b];
		end
	end

	always_comb begin
		head_d = DW'(head_q) - BASE_D;
		tail_d = DW'(tail_q) - BASE_D;
		id_d   = DW'(cmd.given_id) - BASE_D;
		head_ok = (DW'(head_q) >= BASE_D) && (head_d < CAP_D);
		tail_ok = (DW'(tail_q) >= BASE_D) && (tail_d < CAP_D);
		id_ok   = (DW'(cmd.given_id) >= BASE_D) && (id_d < DW'(used_q));
		// the tail's link lives in a register until the tail moves on
		head_link = (tail_ok && (head_q == tail_q)) ? tail_link_q : link_rd;
	end

	always_comb begin
		used_n      = used_q;
		head_n      = head_q;
		tail_n      = tail_q;
		tail_link_n = tail_link_q;
		new_id_n    = '0;
		status_n    = ST_OK;
		hit_n       = 1'b0;
		v_we        = 1'b0;
		v_waddr     = id_d[AW-1:0];
		v_wdata     = '0;
		l_we        = 1'b0;
		l_waddr     = tail_d[AW-1:0];
		l_wdata     = cmd.given_id;
		if (start) begin
			case (cmd.action)
				ACT_ALLOC: begin
					if (used_q != CAP_C) begin
						v_we     = 1'b1;
						v_waddr  = used_q[AW-1:0];
						v_wdata  = v_in;
						new_id_n = ID_W'(DW'(used_q) + BASE_D);
						used_n   = used_q + CW'(1);
					end else if (head_ok) begin
						v_we     = 1'b1;
						v_waddr  = head_d[AW-1:0];
						v_wdata  = v_in;
						new_id_n = head_q;
						head_n   = head_link;
						if (head_link == '0) begin
							tail_n = '0;
						end
					end else begin
						status_n = ST_NO_SPACE;
					end
				end
				ACT_FREE: begin
					if (!id_ok) begin
						status_n = ST_RANGE;
					end else begin
						v_we   = 1'b1;
						tail_n = cmd.given_id;
						if (tail_ok) begin
							l_we        = 1'b1;
							tail_link_n = (cmd.given_id == tail_q) ? cmd.given_id : '0;
						end else begin
							head_n      = cmd.given_id;
							tail_link_n = '0;
						end
					end
				end
				ACT_LOOKUP: begin
					if (!id_ok) begin
						status_n = ST_RANGE;
					end else begin
						hit_n = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		next_d = DW'(head_n) - BASE_D;
	end

	ffl_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(VALUE_BITS)
	) u_value_ram (
		.clk  (clk),
		.we   (v_we),
		.waddr(v_waddr),
		.wdata(v_wdata),
		.raddr(id_d[AW-1:0]),
		.rdata(v_rd)
	);

	// link of the next head is fetched every cycle
	ffl_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(ID_W)
	) u_link_ram (
		.clk  (clk),
		.we   (l_we),
		.waddr(l_waddr),
		.wdata(l_wdata),
		.raddr(next_d[AW-1:0]),
		.rdata(link_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			tail_link_q <= '0;
			done_q      <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			used_q      <= used_n;
			head_q      <= head_n;
			tail_q      <= tail_n;
			tail_link_q <= tail_link_n;
			done_q      <= start;
			hit_q       <= hit_n;
		end
	end

	always_ff @(posedge clk) begin
		new_id_q <= new_id_n;
		status_q <= status_n;
	end

	always_comb begin
		result.new_id      = new_id_q;
		result.status      = status_q;
		result.found_value = '0;
		for (int b = 0; b < VALUE_BITS && b < FOUND_W; b++) begin
			result.found_value[b] = hit_q & v_rd[b];
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// tb_top: self-checking testbench for fifo_free_list_id_allocator
// directed table then random allocate/free/lookup traffic, checked against an in-bench model
// depends on ffl_pkg and the allocator rtl
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ffl_pkg::*;

	localparam int CAP = 64;
	localparam int BASE = 8;
	localparam int RANDOM_ITEMS = 1500;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam rsp_t NO_TYPED = '0;

	typedef struct packed {
		cmd_t c;
		logic typed;
		rsp_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	rsp_t result;

	logic use_typed;
	rsp_t typed_answer;

	logic [IN_VAL_W-1:0] bound_val [CAP];
	logic [ID_W-1:0] next_link [CAP];
	logic [ID_W-1:0] ids_used;
	logic [ID_W-1:0] exp_head;
	logic [ID_W-1:0] list_tail;
	logic [ID_W-1:0] held_ids [$];

	rsp_t pending_answers [$];
	row_t plan [$];
	int mismatches;
	int quiet_cycles;

	fifo_free_list_id_allocator #(
		.CAPACITY(CAP),
		.ID_BASE(BASE),
		.VALUE_BITS(IN_VAL_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit id_handed_out(logic [ID_W-1:0] id);
		return id >= BASE && int'(id) - BASE < int'(ids_used);
	endfunction

	function automatic rsp_t answer_for(cmd_t c);
		rsp_t r;
		int idx;
		r = '0;
		case (c.action)
			ACT_ALLOC: begin
				if (ids_used < CAP) begin
					bound_val[ids_used] = c.stored_value;
					r.new_id = ID_W'(ids_used + BASE);
					ids_used = ids_used + 1'b1;
					held_ids.push_back(r.new_id);
				end else if (exp_head >= BASE && int'(exp_head) - BASE < CAP) begin
					idx = int'(exp_head) - BASE;
					r.new_id = exp_head;
					exp_head = next_link[idx];
					if (exp_head == '0)
						list_tail = '0;
					bound_val[idx] = c.stored_value;
					held_ids.push_back(r.new_id);
				end else begin
					r.status = ST_NO_SPACE;
				end
			end
			ACT_FREE: begin
				if (!id_handed_out(c.given_id)) begin
					r.status = ST_RANGE;
				end else begin
					idx = int'(c.given_id) - BASE;
					bound_val[idx] = '0;
					next_link[idx] = '0;
					if (list_tail >= BASE && int'(list_tail) - BASE < CAP)
						next_link[int'(list_tail) - BASE] = c.given_id;
					else
						exp_head = c.given_id;
					list_tail = c.given_id;
					for (int i = 0; i < held_ids.size(); i++) begin
						if (held_ids[i] == c.given_id) begin
							held_ids.delete(i);
							break;
						end
					end
				end
			end
			ACT_LOOKUP: begin
				if (!id_handed_out(c.given_id))
					r.status = ST_RANGE;
				else
					r.found_value = bound_val[int'(c.given_id) - BASE];
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (arst_n) begin
			if (done) begin
				if (pending_answers.size() == 0) begin
					$display("%0t: unexpected result %p", $time, result);
					mismatches++;
				end else begin
					want = pending_answers.pop_front();
					if (result.new_id !== want.new_id) begin
						$display("%0t: new_id expected %0d actual %0d",
							$time, want.new_id, result.new_id);
						mismatches++;
					end
					if (result.found_value !== want.found_value) begin
						$display("%0t: found_value expected %h actual %h",
							$time, want.found_value, result.found_value);
						mismatches++;
					end
					if (result.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, result.status);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				got = answer_for(cmd);
				pending_answers.push_back(use_typed ? typed_answer : got);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_item(input cmd_t c, input logic typed, input rsp_t want,
		input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		use_typed <= typed;
		typed_answer <= want;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic make_random_item(input bit free_heavy, input bit late, output cmd_t c);
		int roll;
		int alloc_w;
		int free_w;
		int look_w;
		roll = $urandom_range(99);
		alloc_w = free_heavy ? 20 : 55;
		free_w = free_heavy ? 45 : 20;
		look_w = free_heavy ? 30 : 20;
		c.stored_value = $urandom;
		c.given_id = ID_W'($urandom_range(127));
		if (late && list_tail != '0 && $urandom_range(3) == 0) begin
			// freeing the tail twice makes the list loop on itself
			c.action = ACT_FREE;
			c.given_id = list_tail;
		end else if (roll < alloc_w) begin
			c.action = ACT_ALLOC;
		end else if (roll < alloc_w + free_w) begin
			c.action = ACT_FREE;
			if (held_ids.size() > 0)
				c.given_id = held_ids[$urandom_range(held_ids.size() - 1)];
			if (c.given_id == list_tail)
				c.action = ACT_LOOKUP;
		end else if (roll < alloc_w + free_w + look_w) begin
			c.action = ACT_LOOKUP;
			roll = $urandom_range(9);
			if (roll < 5 && held_ids.size() > 0)
				c.given_id = held_ids[$urandom_range(held_ids.size() - 1)];
			else if (roll < 8 && ids_used > 0)
				c.given_id = ID_W'(BASE + $urandom_range(ids_used - 1));
		end else begin
			c.action = $urandom_range(1) ? ACT_UNUSED : ACT_FREE;
			if (c.action == ACT_FREE && c.given_id == list_tail && !late)
				c.action = ACT_UNUSED;
		end
	endtask

	initial begin
		cmd_t c;
		int counted;
		int idle_pct;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		use_typed = 1'b0;
		typed_answer = '0;
		mismatches = 0;
		quiet_cycles = 0;
		ids_used = '0;
		exp_head = '0;
		list_tail = '0;

		plan.push_back({{ACT_LOOKUP, 7'd8, 32'd0}, 1'b1, {7'd0, 32'd0, ST_RANGE}});
		plan.push_back({{ACT_FREE, 7'd0, 32'd0}, 1'b1, {7'd0, 32'd0, ST_RANGE}});
		plan.push_back({{ACT_FREE, 7'd127, 32'hFFFFFFFF}, 1'b1, {7'd0, 32'd0, ST_RANGE}});
		plan.push_back({{ACT_UNUSED, 7'd127, 32'hFFFFFFFF}, 1'b1, {7'd0, 32'd0, ST_OK}});
		plan.push_back({{ACT_ALLOC, 7'd127, 32'hFFFFFFFF}, 1'b1, {7'd8, 32'd0, ST_OK}});
		plan.push_back({{ACT_ALLOC, 7'd0, 32'd0}, 1'b1, {7'd9, 32'd0, ST_OK}});
		plan.push_back({{ACT_ALLOC, 7'd85, 32'hA5A55A5A}, 1'b1, {7'd10, 32'd0, ST_OK}});
		plan.push_back({{ACT_LOOKUP, 7'd8, 32'd0}, 1'b1, {7'd0, 32'hFFFFFFFF, ST_OK}});
		plan.push_back({{ACT_LOOKUP, 7'd9, 32'hFFFFFFFF}, 1'b1, {7'd0, 32'd0, ST_OK}});
		plan.push_back({{ACT_LOOKUP, 7'd11, 32'd0}, 1'b1, {7'd0, 32'd0, ST_RANGE}});
		plan.push_back({{ACT_LOOKUP, 7'd7, 32'd0}, 1'b1, {7'd0, 32'd0, ST_RANGE}});
		plan.push_back({{ACT_LOOKUP, 7'd127, 32'd0}, 1'b1, {7'd0, 32'd0, ST_RANGE}});
		plan.push_back({{ACT_FREE, 7'd11, 32'd0}, 1'b1, {7'd0, 32'd0, ST_RANGE}});
		plan.push_back({{ACT_FREE, 7'd8, 32'd0}, 1'b1, {7'd0, 32'd0, ST_OK}});
		plan.push_back({{ACT_LOOKUP, 7'd8, 32'd0}, 1'b1, {7'd0, 32'd0, ST_OK}});
		plan.push_back({{ACT_FREE, 7'd9, 32'd0}, 1'b1, {7'd0, 32'd0, ST_OK}});
		// second free of an id already on the list
		plan.push_back({{ACT_FREE, 7'd8, 32'd0}, 1'b1, {7'd0, 32'd0, ST_OK}});
		plan.push_back({{ACT_LOOKUP, 7'd10, 32'd0}, 1'b1, {7'd0, 32'hA5A55A5A, ST_OK}});
		plan.push_back({{ACT_ALLOC, 7'd42, 32'd1}, 1'b1, {7'd11, 32'd0, ST_OK}});
		plan.push_back({{ACT_FREE, 7'd10, 32'h12345678}, 1'b1, {7'd0, 32'd0, ST_OK}});
		plan.push_back({{ACT_UNUSED, 7'd0, 32'd0}, 1'b1, {7'd0, 32'd0, ST_OK}});
		plan.push_back({{ACT_LOOKUP, 7'd11, 32'd0}, 1'b1, {7'd0, 32'd1, ST_OK}});
		plan.push_back({{ACT_ALLOC, 7'd0, 32'hDEADBEEF}, 1'b0, NO_TYPED});
		plan.push_back({{ACT_LOOKUP, 7'd12, 32'd0}, 1'b0, NO_TYPED});

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_item(plan[i].c, plan[i].typed, plan[i].want, 29);

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			idle_pct = counted < RANDOM_ITEMS / 3 ? 29 :
				counted < 2 * RANDOM_ITEMS / 3 ? 64 : 0;
			make_random_item((counted / 100) % 2 == 1, counted >= RANDOM_ITEMS - 40, c);
			send_item(c, 1'b0, NO_TYPED, idle_pct);
			if (c.action != ACT_UNUSED)
				counted++;
		end
		start <= 1'b0;

		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
rtl/ffl_pkg.sv
rtl/ffl_ram.sv
rtl/fifo_free_list_id_allocator.sv
sim/tb_top.sv
